// ===== rtl/button_debounce_click_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// Button debounce click classifier - assertion macros
// Shared property wrappers; clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define BDCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdcc assertion failed");

// Next-cycle implication.
`define BDCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdcc assertion failed");

`endif

// ===== rtl/bdcc_pkg.sv =====
// ---------------------------------------------------------------------------
// bdcc_pkg
// Widths, register indexes, reset values, pin levels and result struct.
// ---------------------------------------------------------------------------
package bdcc_pkg;

  localparam int unsigned TS_W      = 32;  // millisecond timestamp
  localparam int unsigned CFG_W     = 16;  // configuration register width
  localparam int unsigned CFG_IDX_W = 8;   // configuration index width

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG      = 8'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1500;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd2500;

  // Pin levels (active low)
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  // One result
  typedef struct packed {
    logic press;
    logic fast_click;
    logic release_ev;
    logic slow_click;
    logic stable_level;
  } res_t;

endpackage

// ===== rtl/button_debounce_click_classifier.sv =====
// ---------------------------------------------------------------------------
// Button debounce click classifier
// Debounces an active-low button poll stream and flags press, release,
// fast click and slow click events.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one poll per request, the raw pin
//    level and the millisecond timestamp of that poll.
//  - Result channel (out_valid / out_stall): exactly one result per poll,
//    in poll order, carrying the four event flags and the debounced level.
//  - Config channel (cfg_valid / cfg_ready): writes debounce_ms (index 0),
//    short_max_ms (1) and long_ms (2); other indexes are dropped. Only the
//    low 16 bits matter. Write only while no request is in flight.
//  - Flow: input register, then result register, which drives out_valid
//    and holds the result until taken. Throughput: one request per cycle
//    while the result is not stalled. The 32-bit timestamp subtract and
//    compare against registered state set the clock speed, not the rate.
//  - Stall: a stalled result holds; the input register still fills, and
//    in_stall rises only once both stages hold a request.
//  - Reset (rst_n low, synchronous): registers back to 15 / 1500 / 2500,
//    debounced and raw levels to released, timers disarmed, pipe empty.
// ---------------------------------------------------------------------------
module button_debounce_click_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  // poll input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  input  logic [bdcc_pkg::TS_W-1:0]     in_now_ms,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_press_event,
  output logic                          out_fast_click_event,
  output logic                          out_release_event,
  output logic                          out_slow_click_event,
  output logic                          out_stable_level,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdcc_pkg::CFG_W-1:0]    cfg_data
);

  import bdcc_pkg::*;

  // Config registers
  logic [CFG_W-1:0] debounce_r, short_max_r, long_r;

  // Input stage
  logic            s1_valid_r;
  logic            s1_level_r;
  logic [TS_W-1:0] s1_now_r;

  // Classifier state
  logic            raw_last_r,     raw_last_nxt;
  logic            pending_r,      pending_nxt;
  logic [TS_W-1:0] settle_start_r, settle_start_nxt;
  logic            stable_r,       stable_nxt;
  logic            armed_r,        armed_nxt;
  logic [TS_W-1:0] press_start_r,  press_start_nxt;

  // Result stage
  logic out_valid_r;
  res_t res_r, res_nxt;

  logic out_free;   // result register can take the input stage this cycle
  logic advance;    // request moves from input stage to result stage
  logic in_take;

  // Compute terms
  logic            raw_chg, pend, settle, edge_seen, press, armed_mid;
  logic [TS_W-1:0] start_sel, pstart_sel;
  logic [TS_W-1:0] settle_age, hold_age, long_age;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // --- per-poll classification (one pass) ---
  always_comb begin
    raw_chg    = (s1_level_r != raw_last_r);
    pend       = raw_chg || pending_r;
    start_sel  = raw_chg ? s1_now_r : settle_start_r;
    settle_age = s1_now_r - start_sel;
    // zero debounce settles on the very poll that changed the level
    settle     = pend && (settle_age >= TS_W'(debounce_r));

    stable_nxt   = settle ? s1_level_r : stable_r;
    raw_last_nxt = s1_level_r;
    pending_nxt  = pend && !settle;
    settle_start_nxt = start_sel;

    edge_seen  = (stable_nxt != stable_r);
    press      = edge_seen && (stable_nxt == LVL_PRESSED);
    pstart_sel = press ? s1_now_r : press_start_r;
    press_start_nxt = pstart_sel;

    // hold time measured against the press start held before this poll
    hold_age   = s1_now_r - press_start_r;
    long_age   = s1_now_r - pstart_sel;

    if (press) begin
      armed_mid = 1'b1;
    end else if (edge_seen) begin
      armed_mid = 1'b0;
    end else begin
      armed_mid = armed_r;
    end

    res_nxt.press        = press;
    res_nxt.release_ev   = edge_seen && (stable_nxt == LVL_RELEASED);
    res_nxt.fast_click   = res_nxt.release_ev && (hold_age <= TS_W'(short_max_r));
    // zero long time fires on the press poll itself
    res_nxt.slow_click   = armed_mid && (long_age >= TS_W'(long_r));
    res_nxt.stable_level = stable_nxt;
    armed_nxt            = armed_mid && !res_nxt.slow_click;
  end

  // --- config registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      short_max_r <= SHORT_MAX_RST;
      long_r      <= LONG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_r  <= cfg_data;
        REG_SHORT_MAX: short_max_r <= cfg_data;
        REG_LONG:      long_r      <= cfg_data;
        default: ;     // unknown index dropped
      endcase
    end
  end

  // --- input stage ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_pin_level;
      s1_now_r   <= in_now_ms;
    end
  end

  // --- classifier state, updated as a request leaves the input stage ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r     <= LVL_RELEASED;
      pending_r      <= 1'b0;
      settle_start_r <= '0;
      stable_r       <= LVL_RELEASED;
      armed_r        <= 1'b0;
      press_start_r  <= '0;
    end else if (advance) begin
      raw_last_r     <= raw_last_nxt;
      pending_r      <= pending_nxt;
      settle_start_r <= settle_start_nxt;
      stable_r       <= stable_nxt;
      armed_r        <= armed_nxt;
      press_start_r  <= press_start_nxt;
    end
  end

  // --- result stage ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_press_event      = res_r.press;
  assign out_fast_click_event = res_r.fast_click;
  assign out_release_event    = res_r.release_ev;
  assign out_slow_click_event = res_r.slow_click;
  assign out_stable_level     = res_r.stable_level;

endmodule

// ===== rtl/bdcc_checker.sv =====
// ---------------------------------------------------------------------------
// bdcc_checker
// Port-level checks on the click classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "button_debounce_click_classifier_macros.svh"

module bdcc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_press_event,
  input logic out_fast_click_event,
  input logic out_release_event,
  input logic out_stable_level
);

  logic any_edge;

  assign any_edge = out_press_event || out_release_event;

  // stalled result stays offered
  `BDCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // press and release are opposite edges of one debounced level
  `BDCC_ASSERT_NOW(a_no_both_edges, out_valid, !(out_press_event && out_release_event))
  // a fast click is always a release
  `BDCC_ASSERT_NOW(a_fast_is_release, out_valid && out_fast_click_event, out_release_event)
  // reported level agrees with the edge
  `BDCC_ASSERT_NOW(a_edge_level, out_valid && any_edge, out_stable_level == out_release_event)

endmodule

bind button_debounce_click_classifier bdcc_checker u_bdcc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_press_event      (out_press_event),
  .out_fast_click_event (out_fast_click_event),
  .out_release_event    (out_release_event),
  .out_stable_level     (out_stable_level)
);

// ===== tb/sv/bdcc_click_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bdcc_click_checker
// Watches poll, result and register-write traffic of the click classifier,
// predicts the flags of every accepted poll and compares them in order.
// ---------------------------------------------------------------------------
module bdcc_click_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_pin_level,
  input  logic [bdcc_pkg::TS_W-1:0]       in_now_ms,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_press_event,
  input  logic                            out_fast_click_event,
  input  logic                            out_release_event,
  input  logic                            out_slow_click_event,
  input  logic                            out_stable_level,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bdcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdcc_pkg::CFG_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              outstanding
);
  import bdcc_pkg::*;

  // timing registers as last written
  logic [CFG_W-1:0] debounce_ms_r;
  logic [CFG_W-1:0] short_max_r;
  logic [CFG_W-1:0] long_ms_r;

  // debouncer / classifier state
  logic            raw_seen;
  logic            settling;
  logic [TS_W-1:0] settle_t0;
  logic            level_now;
  logic            level_prev;
  logic            long_armed_r;
  logic [TS_W-1:0] press_t0;

  res_t expected_flags[$];
  res_t got;
  res_t want;
  int   results_seen;

  function automatic res_t classify_poll(input logic pin, input logic [TS_W-1:0] now_ms);
    res_t            r;
    logic [TS_W-1:0] held;
    r = '0;
    if (pin != raw_seen) begin
      raw_seen  = pin;
      settling  = 1'b1;
      settle_t0 = now_ms;
    end
    held = now_ms - settle_t0;
    if (settling && held >= {16'd0, debounce_ms_r}) begin
      level_now = raw_seen;
      settling  = 1'b0;
    end
    if (level_now != level_prev) begin
      if (level_now == LVL_PRESSED) begin
        long_armed_r = 1'b1;
        r.press      = 1'b1;
        press_t0     = now_ms;
      end else begin
        held = now_ms - press_t0;
        if (held <= {16'd0, short_max_r}) r.fast_click = 1'b1;
        r.release_ev = 1'b1;
        long_armed_r = 1'b0;
      end
      level_prev = level_now;
    end
    held = now_ms - press_t0;
    if (long_armed_r && held >= {16'd0, long_ms_r}) begin
      r.slow_click = 1'b1;
      long_armed_r = 1'b0;
    end
    r.stable_level = level_now;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_flag(input string name, input logic w, input logic g);
    if (g !== w)
      report_mismatch($sformatf("result %0d %s: expected %0b, got %0b",
                                results_seen, name, w, g));
  endtask

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r = DEBOUNCE_RST;
      short_max_r   = SHORT_MAX_RST;
      long_ms_r     = LONG_RST;
      raw_seen      = LVL_RELEASED;
      settling      = 1'b0;
      settle_t0     = '0;
      level_now     = LVL_RELEASED;
      level_prev    = LVL_RELEASED;
      long_armed_r  = 1'b0;
      press_t0      = '0;
      expected_flags.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:  debounce_ms_r = cfg_data;
          REG_SHORT_MAX: short_max_r   = cfg_data;
          REG_LONG:      long_ms_r     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_flags.push_back(classify_poll(in_pin_level, in_now_ms));
      if (out_valid && !out_stall) begin
        got.press        = out_press_event;
        got.fast_click   = out_fast_click_event;
        got.release_ev   = out_release_event;
        got.slow_click   = out_slow_click_event;
        got.stable_level = out_stable_level;
        if (expected_flags.size() == 0) begin
          report_mismatch($sformatf("result %0d with no poll waiting", results_seen));
        end else begin
          want = expected_flags.pop_front();
          check_flag("press",        want.press,        got.press);
          check_flag("fast_click",   want.fast_click,   got.fast_click);
          check_flag("release",      want.release_ev,   got.release_ev);
          check_flag("slow_click",   want.slow_click,   got.slow_click);
          check_flag("stable_level", want.stable_level, got.stable_level);
        end
        results_seen++;
      end
    end
    outstanding = expected_flags.size();
  end

endmodule

// ===== tb/sv/tb_button_debounce_click_classifier.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_button_debounce_click_classifier
// Drives poll requests (pin level + ms timestamp) and timing register writes
// into the click classifier; a checker beside the block predicts and
// compares every result. Directed corner polls first, then press/release
// episodes with bounce, wrap and backwards time under random handshakes.
// ---------------------------------------------------------------------------
module tb_button_debounce_click_classifier;
  import bdcc_pkg::*;

  localparam int PIPE_DEPTH     = 2;     // input register + result register
  localparam int QUIET_LIMIT    = 1000;  // cycles with no handshake at all
  localparam int SQUEEZE_CYCLES = 80;    // long receiver hold-off
  localparam int PHASE_POLLS    = 172;   // minimum polls per timing setting

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_pin_level;
  logic [TS_W-1:0]      in_now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_press_event;
  logic                 out_fast_click_event;
  logic                 out_release_event;
  logic                 out_slow_click_event;
  logic                 out_stable_level;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int              fail_count;
  int              outstanding;
  int              polls_sent;
  int              quiet_cycles;
  logic            last_pin;     // level of the most recent poll request
  logic [TS_W-1:0] ms_now;       // running timestamp of the episode generator
  logic            gaps_on;      // random idling on both sides
  logic            squeeze_req;  // ask the receiver for one long hold-off

  button_debounce_click_classifier DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pin_level         (in_pin_level),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_press_event      (out_press_event),
    .out_fast_click_event (out_fast_click_event),
    .out_release_event    (out_release_event),
    .out_slow_click_event (out_slow_click_event),
    .out_stable_level     (out_stable_level),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  bdcc_click_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pin_level         (in_pin_level),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_press_event      (out_press_event),
    .out_fast_click_event (out_fast_click_event),
    .out_release_event    (out_release_event),
    .out_slow_click_event (out_slow_click_event),
    .out_stable_level     (out_stable_level),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .outstanding          (outstanding)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: any accepted request, result or register write restarts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_button_debounce_click_classifier failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // two pipe stages fill and in_stall rises while polls keep coming.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req && hold_left == 0) begin
        hold_left   = SQUEEZE_CYCLES;
        squeeze_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // One poll request; entered and left on a falling edge. Valid stays high
  // after acceptance - the next call either replaces the payload or idles.
  task automatic send_poll(input logic pin, input logic [TS_W-1:0] stamp);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= pin;
    in_now_ms    <= stamp;
    last_pin      = pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polls_sent++;
    @(negedge clk);
  endtask

  // Stop polling and let every outstanding result drain before a register
  // write; every poll yields a result, so a short tail is enough.
  task automatic settle_pipe();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Register write; the task drops valid and idles before it returns, so valid
  // never drops and rises within the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One button episode: a little contact bounce, then a hold at the opposite
  // level long enough (mostly) to settle. Some episodes are too short to
  // settle, some are plain noise with arbitrary timestamps.
  task automatic press_episode(input int step_max, input int bounce_step);
    logic target;
    int   kind;
    int   bounces;
    int   holds;
    kind   = $urandom_range(0, 99);
    target = ~last_pin;
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) begin
        ms_now = $urandom();
        send_poll(1'($urandom_range(0, 1)), ms_now);
      end
    end else begin
      bounces = $urandom_range(0, 3);
      holds   = (kind < 16) ? $urandom_range(1, 2) : $urandom_range(1, 30);
      repeat (bounces) begin
        ms_now += $urandom_range(0, bounce_step);
        send_poll(1'($urandom_range(0, 1)), ms_now);
      end
      repeat (holds) begin
        // now and then the clock steps backwards
        if ($urandom_range(0, 99) < 2) ms_now -= $urandom_range(1, step_max);
        else ms_now += $urandom_range(0, step_max);
        send_poll(target, ms_now);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] shrt,
                           input logic [CFG_W-1:0] lng, input logic squeeze);
    int                   first;
    int                   step_max;
    int                   bounce_step;
    logic [CFG_IDX_W-1:0] stray_idx;
    settle_pipe();
    write_reg(REG_DEBOUNCE,  deb);
    write_reg(REG_SHORT_MAX, shrt);
    write_reg(REG_LONG,      lng);
    stray_idx = CFG_IDX_W'($urandom_range(3, 255));
    write_reg(stray_idx, CFG_W'($urandom_range(0, 65535)));  // must be dropped
    // time steps scaled so holds reach the long-press time now and then
    step_max    = 1 + (int'(lng) + int'(deb)) / 12;
    bounce_step = 1 + int'(deb) / 4;
    ms_now      = $urandom();
    if (squeeze) squeeze_req = 1'b1;
    first = polls_sent;
    while (polls_sent - first < PHASE_POLLS) press_episode(step_max, bounce_step);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pin_level = LVL_RELEASED;
    in_now_ms    = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    gaps_on      = 1'b1;
    squeeze_req  = 1'b0;
    polls_sent   = 0;
    last_pin     = LVL_RELEASED;
    ms_now       = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset timing (15 / 1500 / 2500 ms)
    send_poll(LVL_RELEASED, 32'd0);
    send_poll(LVL_PRESSED,  32'd100);           // raw change, settling
    send_poll(LVL_PRESSED,  32'd120);           // settled: press
    send_poll(LVL_RELEASED, 32'd500);
    send_poll(LVL_RELEASED, 32'd520);           // release, fast click
    send_poll(LVL_PRESSED,  32'hFFFF_FFF0);
    send_poll(LVL_PRESSED,  32'h0000_0005);     // settles across the wrap
    send_poll(LVL_PRESSED,  32'd3000);          // slow click
    send_poll(LVL_RELEASED, 32'd3010);
    send_poll(LVL_RELEASED, 32'd3030);          // release, too long for fast
    send_poll(LVL_PRESSED,  32'd4000);
    send_poll(LVL_PRESSED,  32'd3990);          // time backwards: settles at once
    send_poll(LVL_RELEASED, 32'd3980);
    send_poll(LVL_RELEASED, 32'd3970);          // backwards hold: no fast click

    // All zero: immediate settle, slow click with the press, zero-hold fast
    // click. Stray indexes written afterwards must leave them alone.
    settle_pipe();
    write_reg(REG_DEBOUNCE,  '0);
    write_reg(REG_SHORT_MAX, '0);
    write_reg(REG_LONG,      '0);
    write_reg(8'd3,   16'hFFFF);
    write_reg(8'hFF,  16'hFFFF);
    send_poll(LVL_PRESSED,  32'd5000);
    send_poll(LVL_RELEASED, 32'd5000);
    send_poll(LVL_RELEASED, 32'd5001);

    // All ones
    settle_pipe();
    write_reg(REG_DEBOUNCE,  16'hFFFF);
    write_reg(REG_SHORT_MAX, 16'hFFFF);
    write_reg(REG_LONG,      16'hFFFF);
    send_poll(LVL_PRESSED,  32'hFFFF_FFFF);
    send_poll(LVL_PRESSED,  32'h0000_FFFE);     // exactly debounce_ms later
    send_poll(LVL_PRESSED,  32'h0001_FFFD);     // exactly long_ms held
    send_poll(LVL_RELEASED, 32'h0002_0000);
    send_poll(LVL_RELEASED, 32'h0002_FFFF);

    // Random episodes over several timing settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 300)),
                     CFG_W'($urandom_range(0, 500)), 1'b1);
        1: begin
          gaps_on = 1'b0;  // a long stretch at full rate on both sides
          run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 300)),
                    CFG_W'($urandom_range(0, 500)), 1'b0);
        end
        2: begin
          gaps_on = 1'b1;
          run_phase('0, '0, '0, 1'b0);
        end
        3: run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        default: run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 2000)),
                           CFG_W'($urandom_range(0, 3000)), 1'b0);
      endcase
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (2 * PIPE_DEPTH) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_button_debounce_click_classifier passed");
    end else begin
      $display("tb_button_debounce_click_classifier failed");
    end
    $finish;
  end

endmodule
